// ----- rtl/core/fqd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared sizes, codes and control types of the linked-list FIFO queue.
// ----------------------------------------------------------------------------
package fqd_pkg;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned HANDLE_WIDTH = 16;
  localparam int unsigned SLOT_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W        = $clog2(CAPACITY + 1);

  // Stream payload layout
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  typedef logic [SLOT_W-1:0]       slot_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [HANDLE_WIDTH-1:0] handle_t;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_DEL = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Control from the sequencer to the free-slot map
  typedef struct packed {
    logic  alloc;
    logic  rel;
    slot_t rel_slot;
  } fm_ctrl_t;

endpackage

// ----- rtl/core/fqd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fqd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/core/fqd_free_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_free_map
// Free-slot bitmap with a lowest-free-slot priority encoder.
// ----------------------------------------------------------------------------
module fqd_free_map import fqd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fm_ctrl_t ctrl_i,
  output slot_t    free_slot_o,
  output logic     any_free_o
);

  logic [CAPACITY-1:0] free_q, free_d;

  // Lowest-numbered free slot wins
  always_comb begin
    free_slot_o = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        free_slot_o = SLOT_W'(i);
      end
    end
  end

  assign any_free_o = |free_q;

  always_comb begin
    free_d = free_q;
    if (ctrl_i.alloc) begin
      free_d[free_slot_o] = 1'b0;
    end
    if (ctrl_i.rel) begin
      free_d[ctrl_i.rel_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '1;
    end else begin
      free_q <= free_d;
    end
  end

endmodule

// ----- rtl/core/fifo_queue_with_delete_by_value.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_by_value
// Bounded FIFO of handles kept as a linked list in a slot RAM pair.
// ----------------------------------------------------------------------------
// Sequence: an enqueue passes S_ENQ and a dequeue S_LOOK, then S_RESP loads the result;
//   a delete stays in S_LOOK, following the list entry by entry to a match or the
//   end; a refusal on an empty queue or an unused code goes straight to S_RESP.
// Flow: one request at a time; the next is taken in S_IDLE once the result sits in
//   the output register, which a stall on the output can hold back.
// Reset: queue empty, all slots free; slot RAMs are not cleared.
module fifo_queue_with_delete_by_value import fqd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [1:0] operation, [17:2] value, [23:18] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [1:0] status, [17:2] value_out, [22:18] item_count, [23] empty_flag
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENQ,
    S_LOOK,
    S_RESP
  } state_e;

  state_e    state_q, state_d;
  op_e       op_q, op_d;
  handle_t   val_q, val_d;
  slot_t     head_q, head_d, tail_q, tail_d;
  slot_t     cur_q, cur_d, prev_q, prev_d;
  logic      have_prev_q, have_prev_d;
  cnt_t      cnt_q, cnt_d, step_q, step_d;
  status_e   status_q, status_d;
  handle_t   got_q, got_d;
  logic      m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;

  // RAM ports
  logic    hnd_we, nxt_we;
  slot_t   hnd_waddr, nxt_waddr, nxt_wdata, rd_addr;
  handle_t hnd_wdata, hnd_rd;
  slot_t   nxt_rd;

  fm_ctrl_t fm_ctrl;
  slot_t    free_slot;
  logic     any_free;

  logic in_acc;
  cnt_t step_inc;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign step_inc = step_q + cnt_t'(1);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Read the head on request, then follow the next pointer during a walk
  assign rd_addr = (state_q == S_LOOK) ? nxt_rd : head_q;

  fqd_ram #(.WIDTH(HANDLE_WIDTH), .DEPTH(CAPACITY)) u_hnd_ram (
    .clk_i   (clk_i),
    .we_i    (hnd_we),
    .waddr_i (hnd_waddr),
    .wdata_i (hnd_wdata),
    .raddr_i (rd_addr),
    .rdata_o (hnd_rd)
  );

  fqd_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_nxt_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .raddr_i (rd_addr),
    .rdata_o (nxt_rd)
  );

  fqd_free_map u_free_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (fm_ctrl),
    .free_slot_o (free_slot),
    .any_free_o  (any_free)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    cnt_d       = cnt_q;
    step_d      = step_q;
    status_d    = status_q;
    got_d       = got_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;

    hnd_we    = 1'b0;
    hnd_waddr = free_slot;
    hnd_wdata = val_q;
    nxt_we    = 1'b0;
    nxt_waddr = tail_q;
    nxt_wdata = free_slot;
    fm_ctrl   = '{alloc: 1'b0, rel: 1'b0, rel_slot: cur_q};

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d        = op_e'(s_axis_tdata_i[1:0]);
          val_d       = HANDLE_WIDTH'(s_axis_tdata_i[17:2]);
          got_d       = '0;
          status_d    = ST_OK;
          cur_d       = head_q;
          have_prev_d = 1'b0;
          step_d      = '0;
          case (op_e'(s_axis_tdata_i[1:0]))
            OP_ENQ: state_d = S_ENQ;
            OP_DEQ, OP_DEL: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                state_d = S_LOOK;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end

      S_ENQ: begin
        if (!any_free || cnt_q >= cnt_t'(CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          hnd_we        = 1'b1;
          nxt_we        = (cnt_q != '0);
          fm_ctrl.alloc = 1'b1;
          if (cnt_q == '0) begin
            head_d = free_slot;
          end
          tail_d = free_slot;
          cnt_d  = cnt_q + cnt_t'(1);
        end
        state_d = S_RESP;
      end

      S_LOOK: begin
        if (op_q == OP_DEQ) begin
          got_d         = hnd_rd;
          head_d        = nxt_rd;
          fm_ctrl.rel   = 1'b1;
          cnt_d         = cnt_q - cnt_t'(1);
          if (cnt_q == cnt_t'(1)) begin
            head_d = '0;
            tail_d = '0;
          end
          state_d = S_RESP;
        end else if (hnd_rd == val_q) begin
          // Unlink the match and splice its successor in
          if (!have_prev_q) begin
            head_d = nxt_rd;
          end else begin
            nxt_we    = 1'b1;
            nxt_waddr = prev_q;
            nxt_wdata = nxt_rd;
          end
          if (have_prev_q && cur_q == tail_q && step_inc == cnt_q) begin
            tail_d = prev_q;
          end
          fm_ctrl.rel = 1'b1;
          cnt_d       = cnt_q - cnt_t'(1);
          if (cnt_q == cnt_t'(1)) begin
            head_d = '0;
            tail_d = '0;
          end
          state_d = S_RESP;
        end else if (step_inc >= cnt_q) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_RESP;
        end else begin
          // Advance: the read at the successor is already issued
          prev_d      = cur_q;
          have_prev_d = 1'b1;
          cur_d       = nxt_rd;
          step_d      = step_inc;
        end
      end

      S_RESP: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {(cnt_q == '0), 5'(cnt_q), 16'(got_q), status_q};
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      m_valid_q   <= 1'b0;
      have_prev_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      m_valid_q   <= m_valid_d;
      have_prev_q <= have_prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    step_q   <= step_d;
    status_q <= status_d;
    got_q    <= got_d;
    m_data_q <= m_data_d;
  end

endmodule

// ----- rtl/core/fqd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_checker
// Port-level checks of the linked-list FIFO queue, bound to the top level.
// ----------------------------------------------------------------------------
module fqd_checker import fqd_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // Held result stays put while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[23] == (m_axis_tdata_o[22:18] == 5'd0)))
    else $error("empty flag disagrees with count");

  a_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[17:2] != 16'd0) |-> m_axis_tdata_o[1:0] == ST_OK)
    else $error("handle returned with failing status");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[1:0] == ST_FULL) |->
      m_axis_tdata_o[22:18] == 5'(CAPACITY))
    else $error("full reported below capacity");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while busy");

endmodule

bind fifo_queue_with_delete_by_value fqd_checker u_fqd_checker (.*);
